// ----- sv/bagu_pkg.sv -----
package bagu_pkg;

  localparam int DATA_W = 16;
  localparam int COL_W = 10;
  localparam int ROW_LENGTH_MAX_DEF = 1024;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // 1/sqrt2 in q0.16
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;
  localparam logic [16:0] ERF_ONE = 17'd65536;

  // erf(k/16) in q0.16, k = 0..64
  localparam logic [16:0] ERF_ROM [0:64] = '{
    17'd0,     17'd4616,  17'd9196,  17'd13705, 17'd18109, 17'd22378, 17'd26484, 17'd30402,
    17'd34111, 17'd37596, 17'd40845, 17'd43849, 17'd46606, 17'd49117, 17'd51385, 17'd53419,
    17'd55227, 17'd56824, 17'd58221, 17'd59436, 17'd60483, 17'd61379, 17'd62139, 17'd62780,
    17'd63315, 17'd63758, 17'd64123, 17'd64421, 17'd64663, 17'd64856, 17'd65011, 17'd65133,
    17'd65229, 17'd65304, 17'd65362, 17'd65406, 17'd65440, 17'd65466, 17'd65485, 17'd65499,
    17'd65509, 17'd65517, 17'd65523, 17'd65527, 17'd65529, 17'd65531, 17'd65533, 17'd65534,
    17'd65535, 17'd65535, 17'd65535, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
    17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
    17'd65536
  };

endpackage

// ----- sv/bagu_if.sv -----
interface bagu_in_if import bagu_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [COL_W-1:0]         column;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output column, output value, input ready);
  modport sink (input valid, input action, input column, input value, output ready);
endinterface

interface bagu_out_if import bagu_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] activation;
  logic [COL_W-1:0]         out_column;

  modport source (output valid, output activation, output out_column, input ready);
  modport sink (input valid, input activation, input out_column, output ready);
endinterface

// ----- sv/bagu_ram.sv -----
module bagu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bias_add_gelu_unit.sv -----
// Bias add followed by exact-erf GELU on signed q8.8 samples. A request with action load
// writes its value into the bias store at its column; a request with action sample adds the
// stored bias for its column (saturating), applies y = 0.5*v*(1+erf(v/sqrt2)) with a
// 64-segment piecewise-linear erf table and gives one result carrying the same column.
// Loads give no result. One request is taken every clock cycle; each sample passes every
// stage and the output register. Only the output handshake sets the rate: when the output
// register holds a result that is not taken, the whole pipeline and in_ch.ready hold. The
// bias store is a single RAM with one write and one registered read per cycle, so a sample
// right behind a load of the same column already sees the new bias. The store is not cleared
// at reset: every column must be loaded before a sample reads it. Columns wrap modulo
// ROW_LENGTH_MAX when that is below 1024.
module bias_add_gelu_unit import bagu_pkg::*; #(
  parameter int ROW_LENGTH_MAX = ROW_LENGTH_MAX_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bagu_in_if.sink   in_ch,
  bagu_out_if.source out_ch
);

  localparam int DEPTH = (ROW_LENGTH_MAX < (1 << COL_W)) ? ROW_LENGTH_MAX : (1 << COL_W);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RECIP_SH = 2 * COL_W;

  // ---------------------------------------------------------------- pipeline control
  // one enable for every stage: the pipe only stops when the output register is stuck
  logic en;
  logic acc;
  logic out_valid_r;

  assign en = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready = en;
  assign acc = in_ch.valid && en;

  // ---------------------------------------------------------------- store index
  logic [COL_W-1:0]  idx_full;
  logic [ADDR_W-1:0] idx;

  generate
    if (ROW_LENGTH_MAX >= (1 << COL_W)) begin : g_idx_direct
      assign idx_full = in_ch.column;
    end else begin : g_idx_wrap
      // column mod ROW_LENGTH_MAX by reciprocal; exact for every 10-bit column
      localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH+1)'(((1 << RECIP_SH) + ROW_LENGTH_MAX - 1) / ROW_LENGTH_MAX);
      localparam logic [COL_W-1:0] ROW_LEN = COL_W'(ROW_LENGTH_MAX);
      logic [COL_W+RECIP_SH:0] qprod;
      logic [COL_W-1:0]        quot;
      logic [2*COL_W-1:0]      qmul;
      assign qprod = (COL_W+RECIP_SH+1)'(in_ch.column) * RECIP;
      assign quot = qprod[RECIP_SH+COL_W-1:RECIP_SH];
      assign qmul = quot * ROW_LEN;
      assign idx_full = in_ch.column - qmul[COL_W-1:0];
    end
  endgenerate

  assign idx = idx_full[ADDR_W-1:0];

  // ---------------------------------------------------------------- bias store
  logic [DATA_W-1:0] bias_rd;
  logic              ram_we;
  logic              ram_re;

  assign ram_we = acc && (in_ch.action == ACT_LOAD);
  assign ram_re = acc && (in_ch.action == ACT_SAMPLE);

  bagu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_bias_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (in_ch.value),
    .re    (ram_re),
    .raddr (idx),
    .rdata (bias_rd)
  );

  // ---------------------------------------------------------------- stage 1: bias read
  // bias_rd lines up with this stage; it only changes on a new sample read
  logic                     s1_valid_r;
  logic [COL_W-1:0]         s1_col_r;
  logic signed [DATA_W-1:0] s1_sample_r;

  // ---------------------------------------------------------------- stage 2: saturated sum
  logic                     s2_valid_r;
  logic [COL_W-1:0]         s2_col_r;
  logic signed [DATA_W-1:0] s2_v_r, s2_v_nxt;
  logic [DATA_W-1:0]        s2_a_r, s2_a_nxt;
  logic signed [DATA_W:0]   sum;

  always_comb begin
    sum = {s1_sample_r[DATA_W-1], s1_sample_r} + {bias_rd[DATA_W-1], bias_rd};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      // overflow: clip to the q8.8 end that the sign of the true sum points at
      s2_v_nxt = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      s2_v_nxt = sum[DATA_W-1:0];
    end
    // |v|; the most negative value maps to 0x8000 read as unsigned
    s2_a_nxt = s2_v_nxt[DATA_W-1] ? (~s2_v_nxt + 1'b1) : s2_v_nxt;
  end

  // ---------------------------------------------------------------- stage 3: |v| / sqrt2
  logic                     s3_valid_r;
  logic [COL_W-1:0]         s3_col_r;
  logic signed [DATA_W-1:0] s3_v_r;
  logic [31:0]              s3_zp_r, s3_zp_nxt;

  assign s3_zp_nxt = s2_a_r * INV_SQRT2_Q16;

  // ---------------------------------------------------------------- stage 4: erf table
  logic                     s4_valid_r;
  logic [COL_W-1:0]         s4_col_r;
  logic signed [DATA_W-1:0] s4_v_r;
  logic                     s4_sat_r, s4_sat_nxt;
  logic [16:0]              s4_lo_r, s4_lo_nxt;
  logic [20:0]              s4_dp_r, s4_dp_nxt;
  logic [31:0]              zsum;
  logic [19:0]              z12;
  logic [5:0]               seg;
  logic [7:0]               frac;
  logic [16:0]              erf_hi;
  logic [16:0]              erf_diff;

  always_comb begin
    zsum = s3_zp_r + 32'd2048;
    z12 = zsum[31:12];
    // beyond |z| = 4 erf is taken as one
    s4_sat_nxt = |z12[19:14];
    seg = z12[13:8];
    frac = z12[7:0];
    s4_lo_nxt = ERF_ROM[7'(seg)];
    erf_hi = ERF_ROM[7'(seg) + 7'd1];
    erf_diff = erf_hi - s4_lo_nxt;
    s4_dp_nxt = erf_diff[12:0] * frac;
  end

  // ---------------------------------------------------------------- stage 5: 1 +- erf
  logic                     s5_valid_r;
  logic [COL_W-1:0]         s5_col_r;
  logic signed [DATA_W-1:0] s5_v_r;
  logic [17:0]              s5_s_r, s5_s_nxt;
  logic [20:0]              dp_rnd;
  logic [16:0]              erf_mag;

  always_comb begin
    dp_rnd = s4_dp_r + 21'd128;
    erf_mag = s4_sat_r ? ERF_ONE : (s4_lo_r + 17'(dp_rnd[20:8]));
    if (s4_v_r[DATA_W-1]) begin
      s5_s_nxt = 18'(ERF_ONE) - 18'(erf_mag);
    end else begin
      s5_s_nxt = 18'(ERF_ONE) + 18'(erf_mag);
    end
  end

  // ---------------------------------------------------------------- stage 6: v * s
  logic                     s6_valid_r;
  logic [COL_W-1:0]         s6_col_r;
  logic signed [34:0]       s6_p_r, s6_p_nxt;

  assign s6_p_nxt = s5_v_r * $signed({1'b0, s5_s_r});

  // ---------------------------------------------------------------- output: round, clamp
  logic signed [DATA_W-1:0] out_act_r, out_act_nxt;
  logic [COL_W-1:0]         out_col_r;
  logic signed [35:0]       p_rnd;
  logic signed [18:0]       y_w;

  always_comb begin
    // divide by 2^17 with round half up
    p_rnd = {s6_p_r[34], s6_p_r} + 36'sd65536;
    y_w = p_rnd[35:17];
    if (y_w > 19'sd32767) begin
      out_act_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (y_w < -19'sd32768) begin
      out_act_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      out_act_nxt = y_w[DATA_W-1:0];
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= ram_re;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
      out_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col_r <= in_ch.column;
      s1_sample_r <= in_ch.value;
      s2_col_r <= s1_col_r;
      s2_v_r <= s2_v_nxt;
      s2_a_r <= s2_a_nxt;
      s3_col_r <= s2_col_r;
      s3_v_r <= s2_v_r;
      s3_zp_r <= s3_zp_nxt;
      s4_col_r <= s3_col_r;
      s4_v_r <= s3_v_r;
      s4_sat_r <= s4_sat_nxt;
      s4_lo_r <= s4_lo_nxt;
      s4_dp_r <= s4_dp_nxt;
      s5_col_r <= s4_col_r;
      s5_v_r <= s4_v_r;
      s5_s_r <= s5_s_nxt;
      s6_col_r <= s5_col_r;
      s6_p_r <= s6_p_nxt;
      out_col_r <= s6_col_r;
      out_act_r <= out_act_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.activation = out_act_r;
  assign out_ch.out_column = out_col_r;

endmodule

// ----- sv/bagu_checker.sv -----
module bagu_checker import bagu_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_action,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_activation,
  input logic [COL_W-1:0]         out_column
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_activation) && $stable(out_column))
    else $error("result changed while waiting");

  // input only backs off while a result is stuck at the output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a sample that moves through every stage without a stall reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_action == ACT_SAMPLE)) ##1 in_ready ##1 in_ready
      ##1 in_ready ##1 in_ready ##1 in_ready ##1 in_ready |=> out_valid)
    else $error("sample result missing");

endmodule

bind bias_add_gelu_unit bagu_checker u_bagu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_action      (in_ch.action),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_activation (out_ch.activation),
  .out_column     (out_ch.out_column)
);
